FILE: design/mse_pkg.sv
// Package for the Modbus server register/coil engine.
// Sizes, codes and the memory request/response structs; no dependencies.
`timescale 1ns / 1ps

package mse_pkg;

	localparam int REG_COUNT  = 32;
	localparam int COIL_COUNT = 256;
	localparam int REG_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int COIL_AW    = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
	localparam int CLR_N      = (REG_COUNT > COIL_COUNT) ? REG_COUNT : COIL_COUNT;
	localparam int CLR_W      = (CLR_N > 1) ? $clog2(CLR_N) : 1;
	localparam int QTY_W      = 11;
	localparam int LEFT_W     = 7;

	localparam logic [15:0] MAX_REG_READ   = 16'd125;
	localparam logic [15:0] MAX_BIT_READ   = 16'd2000;
	localparam logic [15:0] MAX_COIL_WRITE = 16'd1968;
	localparam logic [15:0] MAX_REG_WRITE  = 16'd123;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [15:0] COIL_ON        = 16'hFF00;
	localparam logic [15:0] COIL_OFF       = 16'h0000;

	localparam logic [1:0] OP_HDR     = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_LOAD_IR = 2'd2;
	localparam logic [1:0] OP_LOAD_DI = 2'd3;

	localparam logic [1:0] KIND_RDHDR = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_EXC   = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	localparam logic [15:0] EXC_FUNC  = 16'd0;
	localparam logic [15:0] EXC_ADDR  = 16'd1;
	localparam logic [15:0] EXC_VALUE = 16'd2;

	localparam logic [7:0] FC_RD_COILS = 8'd1;
	localparam logic [7:0] FC_RD_DISC  = 8'd2;
	localparam logic [7:0] FC_RD_HOLD  = 8'd3;
	localparam logic [7:0] FC_RD_INP   = 8'd4;
	localparam logic [7:0] FC_WR_COIL  = 8'd5;
	localparam logic [7:0] FC_WR_REG   = 8'd6;
	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam logic [1:0] PK_NONE  = 2'd0;
	localparam logic [1:0] PK_COILS = 2'd1;
	localparam logic [1:0] PK_REGS  = 2'd2;

	typedef struct packed {
		logic               hold_we;
		logic [REG_AW-1:0]  hold_waddr;
		logic [15:0]        hold_wdata;
		logic               inp_we;
		logic [REG_AW-1:0]  inp_waddr;
		logic [15:0]        inp_wdata;
		logic [REG_AW-1:0]  reg_raddr;
		logic               coil_we;
		logic [COIL_AW-1:0] coil_waddr;
		logic               coil_wdata;
		logic               disc_we;
		logic [COIL_AW-1:0] disc_waddr;
		logic               disc_wdata;
		logic [COIL_AW-1:0] bit_raddr;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] hold_rdata;
		logic [15:0] inp_rdata;
		logic        coil_rdata;
		logic        disc_rdata;
	} mem_rsp_t;

endpackage

FILE: design/modbus_server_register_coil_engine_top.sv
// Top level of the Modbus server register/coil engine: unit id register and table RAMs.
// Uses mse_pkg, mse_ram and mse_ctrl.
//
// channel   signals                                          handshake
// request   op func_code start_addr quantity data_word       start & !busy
// result    kind unit_addr resp_func field_a field_b
//           resp_data last                                   valid, one cycle
// config    cfg_wdata                                        cfg_we
//
// Register reads: result header, then one data word per cycle;
// busy through the read and drain states after the header is taken.
// Coil/discrete reads go through the bit RAM one bit per cycle, with busy high.
// A coil payload item keeps busy high while its word is written to the coil RAM bit by bit.
// After reset a clearing pass zeroes all tables with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps

module modbus_server_register_coil_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  func_code,
	input  logic [15:0] start_addr,
	input  logic [15:0] quantity,
	input  logic [15:0] data_word,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        valid,
	output logic [1:0]  kind,
	output logic [7:0]  unit_addr,
	output logic [7:0]  resp_func,
	output logic [15:0] field_a,
	output logic [15:0] field_b,
	output logic [15:0] resp_data,
	output logic        last
);

	mse_pkg::mem_req_t mreq;
	mse_pkg::mem_rsp_t mrsp;
	logic [7:0]        unit_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id_q <= 8'd1;
		end else if (cfg_we) begin
			unit_id_q <= cfg_wdata;
		end
	end

	assign unit_addr = unit_id_q;

	mse_ram #(.WIDTH(16), .DEPTH(mse_pkg::REG_COUNT)) u_hold (
		.clk(clk), .we(mreq.hold_we), .waddr(mreq.hold_waddr), .wdata(mreq.hold_wdata),
		.raddr(mreq.reg_raddr), .rdata(mrsp.hold_rdata)
	);

	mse_ram #(.WIDTH(16), .DEPTH(mse_pkg::REG_COUNT)) u_inp (
		.clk(clk), .we(mreq.inp_we), .waddr(mreq.inp_waddr), .wdata(mreq.inp_wdata),
		.raddr(mreq.reg_raddr), .rdata(mrsp.inp_rdata)
	);

	mse_ram #(.WIDTH(1), .DEPTH(mse_pkg::COIL_COUNT)) u_coil (
		.clk(clk), .we(mreq.coil_we), .waddr(mreq.coil_waddr), .wdata(mreq.coil_wdata),
		.raddr(mreq.bit_raddr), .rdata(mrsp.coil_rdata)
	);

	mse_ram #(.WIDTH(1), .DEPTH(mse_pkg::COIL_COUNT)) u_disc (
		.clk(clk), .we(mreq.disc_we), .waddr(mreq.disc_waddr), .wdata(mreq.disc_wdata),
		.raddr(mreq.bit_raddr), .rdata(mrsp.disc_rdata)
	);

	mse_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.func_code(func_code),
		.start_addr(start_addr),
		.quantity(quantity),
		.data_word(data_word),
		.mreq(mreq),
		.mrsp(mrsp),
		.valid(valid),
		.kind(kind),
		.resp_func(resp_func),
		.field_a(field_a),
		.field_b(field_b),
		.resp_data(resp_data),
		.last(last)
	);

endmodule

FILE: design/mse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mse_ctrl.sv
// Request sequencer: decode, table clear pass, read/write sequencing, result register.
// Uses mse_pkg; drives the table RAMs through mse_pkg::mem_req_t.
`timescale 1ns / 1ps

module mse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic [7:0]          func_code,
	input  logic [15:0]         start_addr,
	input  logic [15:0]         quantity,
	input  logic [15:0]         data_word,
	output mse_pkg::mem_req_t   mreq,
	input  mse_pkg::mem_rsp_t   mrsp,
	output logic                valid,
	output logic [1:0]          kind,
	output logic [7:0]          resp_func,
	output logic [15:0]         field_a,
	output logic [15:0]         field_b,
	output logic [15:0]         resp_data,
	output logic                last
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RDREG = 3'd2;
	localparam logic [2:0] ST_RDBIT = 3'd3;
	localparam logic [2:0] ST_WRBIT = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	localparam int QW = mse_pkg::QTY_W;
	localparam int LW = mse_pkg::LEFT_W;
	localparam int CLR_W = mse_pkg::CLR_W;

	logic [2:0]                  state_q;
	logic [mse_pkg::CLR_W-1:0]   clr_cnt_q;
	logic [7:0]                  func_q;
	logic [15:0]                 addr_q;
	logic [QW-1:0]               qty_q;
	logic [QW-1:0]               cnt_q;
	logic [1:0]                  pend_kind_q;
	logic [15:0]                 pend_addr_q;
	logic [QW-1:0]               pend_count_q;
	logic [LW-1:0]               pend_left_q;
	logic [QW-1:0]               pend_ptr_q;
	logic [15:0]                 wr_word_q;
	logic [3:0]                  bit_i_q;
	logic                        vld_s1, last_s1, wend_s1, isbit_s1;
	logic [3:0]                  pos_s1;
	logic [15:0]                 acc_q;

	logic                        out_vld_q, last_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  rfunc_q;
	logic [15:0]                 fa_q, fb_q, rdata_q;

	logic                        acc_in;
	logic [16:0]                 sum17;
	logic                        bit_rng_bad, reg_rng_bad, q_zero;
	logic [16:0]                 reg_widx, bit_widx, rd_idx;
	logic [QW-1:0]               wr_k;
	logic                        rd_last;
	logic                        rbit;
	logic [15:0]                 acc_n;

	// header decode results
	logic                        o_load, o_last;
	logic [1:0]                  o_kind;
	logic [7:0]                  o_func;
	logic [15:0]                 o_a, o_b, o_data;
	logic [2:0]                  state_n;
	logic                        go_read, pend_set, pend_clr;
	logic [1:0]                  pend_kind_n;

	assign busy    = (state_q != ST_IDLE);
	assign acc_in  = start && (state_q == ST_IDLE);
	assign sum17   = {1'b0, start_addr} + {1'b0, quantity};
	assign q_zero  = (quantity == 16'd0);
	assign bit_rng_bad = sum17 > 17'(mse_pkg::COIL_COUNT);
	assign reg_rng_bad = sum17 > 17'(mse_pkg::REG_COUNT);
	assign reg_widx = {1'b0, pend_addr_q} + 17'(pend_ptr_q);
	assign wr_k     = pend_ptr_q + QW'(bit_i_q);
	assign bit_widx = {1'b0, pend_addr_q} + 17'(wr_k);
	assign rd_idx   = {1'b0, addr_q} + 17'(cnt_q);
	assign rd_last  = (cnt_q == qty_q - QW'(1));
	assign rbit     = (func_q == mse_pkg::FC_RD_COILS) ? mrsp.coil_rdata : mrsp.disc_rdata;
	assign acc_n    = ((pos_s1 == 4'd0) ? 16'd0 : acc_q) | (16'(rbit) << pos_s1);

	always_comb begin
		mreq = '0;
		o_load = 1'b0;
		o_kind = mse_pkg::KIND_EXC;
		o_func = func_code;
		o_a = 16'd0;
		o_b = 16'd0;
		o_data = 16'd0;
		o_last = 1'b1;
		state_n = state_q;
		go_read = 1'b0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		pend_kind_n = mse_pkg::PK_NONE;
		mreq.reg_raddr = rd_idx[mse_pkg::REG_AW-1:0];
		mreq.bit_raddr = rd_idx[mse_pkg::COIL_AW-1:0];

		case (state_q)
			ST_CLR: begin
				mreq.hold_we    = 32'(clr_cnt_q) < mse_pkg::REG_COUNT;
				mreq.inp_we     = 32'(clr_cnt_q) < mse_pkg::REG_COUNT;
				mreq.coil_we    = 32'(clr_cnt_q) < mse_pkg::COIL_COUNT;
				mreq.disc_we    = 32'(clr_cnt_q) < mse_pkg::COIL_COUNT;
				mreq.hold_waddr = mse_pkg::REG_AW'(clr_cnt_q);
				mreq.inp_waddr  = mse_pkg::REG_AW'(clr_cnt_q);
				mreq.coil_waddr = mse_pkg::COIL_AW'(clr_cnt_q);
				mreq.disc_waddr = mse_pkg::COIL_AW'(clr_cnt_q);
				if (32'(clr_cnt_q) == mse_pkg::CLR_N - 1) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc_in) begin
					case (op)
						mse_pkg::OP_HDR: begin
							pend_clr = 1'b1;
							o_load = 1'b1;
							o_func = func_code | mse_pkg::EXC_FLAG;
							case (func_code)
								mse_pkg::FC_RD_COILS, mse_pkg::FC_RD_DISC: begin
									if (q_zero || quantity > mse_pkg::MAX_BIT_READ) begin
										o_a = mse_pkg::EXC_VALUE;
									end else if (bit_rng_bad) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										o_kind = mse_pkg::KIND_RDHDR;
										o_func = func_code;
										o_a = (quantity + 16'd7) >> 3;
										o_b = quantity;
										o_last = 1'b0;
										go_read = 1'b1;
										state_n = ST_RDBIT;
									end
								end
								mse_pkg::FC_RD_HOLD, mse_pkg::FC_RD_INP: begin
									if (q_zero || quantity > mse_pkg::MAX_REG_READ) begin
										o_a = mse_pkg::EXC_VALUE;
									end else if (reg_rng_bad) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										o_kind = mse_pkg::KIND_RDHDR;
										o_func = func_code;
										o_a = quantity << 1;
										o_b = quantity;
										o_last = 1'b0;
										go_read = 1'b1;
										state_n = ST_RDREG;
									end
								end
								mse_pkg::FC_WR_COIL: begin
									if (32'(start_addr) >= mse_pkg::COIL_COUNT) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										mreq.coil_we = (quantity == mse_pkg::COIL_ON) ||
											(quantity == mse_pkg::COIL_OFF);
										mreq.coil_waddr = start_addr[mse_pkg::COIL_AW-1:0];
										mreq.coil_wdata = (quantity == mse_pkg::COIL_ON);
										o_kind = mse_pkg::KIND_ECHO;
										o_func = func_code;
										o_a = start_addr;
										o_b = quantity;
									end
								end
								mse_pkg::FC_WR_REG: begin
									if (32'(start_addr) >= mse_pkg::REG_COUNT) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										mreq.hold_we = 1'b1;
										mreq.hold_waddr = start_addr[mse_pkg::REG_AW-1:0];
										mreq.hold_wdata = quantity;
										o_kind = mse_pkg::KIND_ECHO;
										o_func = func_code;
										o_a = start_addr;
										o_b = quantity;
									end
								end
								mse_pkg::FC_WR_COILS: begin
									if (q_zero || quantity > mse_pkg::MAX_COIL_WRITE) begin
										o_a = mse_pkg::EXC_VALUE;
									end else if (bit_rng_bad) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										o_load = 1'b0;
										pend_set = 1'b1;
										pend_kind_n = mse_pkg::PK_COILS;
									end
								end
								mse_pkg::FC_WR_REGS: begin
									if (q_zero || quantity > mse_pkg::MAX_REG_WRITE) begin
										o_a = mse_pkg::EXC_VALUE;
									end else if (reg_rng_bad) begin
										o_a = mse_pkg::EXC_ADDR;
									end else begin
										o_load = 1'b0;
										pend_set = 1'b1;
										pend_kind_n = mse_pkg::PK_REGS;
									end
								end
								default: begin
									o_a = mse_pkg::EXC_FUNC;
								end
							endcase
						end
						mse_pkg::OP_PAYLOAD: begin
							if (pend_kind_q == mse_pkg::PK_REGS) begin
								mreq.hold_we = reg_widx < 17'(mse_pkg::REG_COUNT);
								mreq.hold_waddr = reg_widx[mse_pkg::REG_AW-1:0];
								mreq.hold_wdata = data_word;
								if (pend_left_q == LW'(1)) begin
									o_load = 1'b1;
									o_kind = mse_pkg::KIND_ECHO;
									o_func = mse_pkg::FC_WR_REGS;
									o_a = pend_addr_q;
									o_b = 16'(pend_count_q);
								end
							end else if (pend_kind_q == mse_pkg::PK_COILS) begin
								state_n = ST_WRBIT;
							end
						end
						mse_pkg::OP_LOAD_IR: begin
							mreq.inp_we = 32'(start_addr) < mse_pkg::REG_COUNT;
							mreq.inp_waddr = start_addr[mse_pkg::REG_AW-1:0];
							mreq.inp_wdata = data_word;
						end
						default: begin
							mreq.disc_we = 32'(start_addr) < mse_pkg::COIL_COUNT;
							mreq.disc_waddr = start_addr[mse_pkg::COIL_AW-1:0];
							mreq.disc_wdata = data_word[0];
						end
					endcase
				end
			end
			ST_WRBIT: begin
				mreq.coil_we = (wr_k < pend_count_q) &&
					(bit_widx < 17'(mse_pkg::COIL_COUNT));
				mreq.coil_waddr = bit_widx[mse_pkg::COIL_AW-1:0];
				mreq.coil_wdata = wr_word_q[bit_i_q];
				if (bit_i_q == 4'd15) begin
					state_n = ST_IDLE;
					if (pend_left_q == LW'(1)) begin
						o_load = 1'b1;
						o_kind = mse_pkg::KIND_ECHO;
						o_func = mse_pkg::FC_WR_COILS;
						o_a = pend_addr_q;
						o_b = 16'(pend_count_q);
					end
				end
			end
			ST_RDREG, ST_RDBIT: begin
				if (rd_last) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// data words leave from the stage after the RAM read
		if (vld_s1 && (!isbit_s1 || wend_s1)) begin
			o_load = 1'b1;
			o_kind = mse_pkg::KIND_DATA;
			o_func = func_q;
			o_a = 16'd0;
			o_b = 16'd0;
			o_last = last_s1;
			o_data = isbit_s1 ? acc_n :
				((func_q == mse_pkg::FC_RD_HOLD) ? mrsp.hold_rdata : mrsp.inp_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_cnt_q <= '0;
			pend_kind_q <= mse_pkg::PK_NONE;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			out_vld_q <= o_load;
			if (state_q == ST_CLR) begin
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			end
			if (pend_set) begin
				pend_kind_q <= pend_kind_n;
			end else if (pend_clr) begin
				pend_kind_q <= mse_pkg::PK_NONE;
			end else if (o_load && o_kind == mse_pkg::KIND_ECHO && !vld_s1) begin
				// final payload item of a multi write
				pend_kind_q <= mse_pkg::PK_NONE;
			end
			vld_s1 <= (state_q == ST_RDREG) || (state_q == ST_RDBIT);
		end
	end

	always_ff @(posedge clk) begin
		if (go_read) begin
			func_q <= func_code;
			addr_q <= start_addr;
			qty_q <= quantity[QW-1:0];
			cnt_q <= '0;
		end else if (state_q == ST_RDREG || state_q == ST_RDBIT) begin
			cnt_q <= cnt_q + QW'(1);
		end
		if (pend_set) begin
			pend_addr_q <= start_addr;
			pend_count_q <= quantity[QW-1:0];
			pend_ptr_q <= '0;
			pend_left_q <= (pend_kind_n == mse_pkg::PK_COILS) ?
				LW'((quantity + 16'd15) >> 4) : LW'(quantity);
		end else if (acc_in && op == mse_pkg::OP_PAYLOAD &&
				pend_kind_q == mse_pkg::PK_REGS) begin
			pend_ptr_q <= pend_ptr_q + QW'(1);
			pend_left_q <= pend_left_q - LW'(1);
		end else if (state_q == ST_WRBIT && bit_i_q == 4'd15) begin
			pend_ptr_q <= pend_ptr_q + QW'(16);
			pend_left_q <= pend_left_q - LW'(1);
		end
		if (acc_in && op == mse_pkg::OP_PAYLOAD) begin
			wr_word_q <= data_word;
			bit_i_q <= 4'd0;
		end else if (state_q == ST_WRBIT) begin
			bit_i_q <= bit_i_q + 4'd1;
		end
		last_s1 <= rd_last;
		wend_s1 <= (cnt_q[3:0] == 4'd15) || rd_last;
		pos_s1 <= cnt_q[3:0];
		isbit_s1 <= (state_q == ST_RDBIT);
		if (vld_s1 && isbit_s1) begin
			acc_q <= acc_n;
		end
		if (o_load) begin
			kind_q <= o_kind;
			rfunc_q <= o_func;
			fa_q <= o_a;
			fb_q <= o_b;
			rdata_q <= o_data;
			last_q <= o_last;
		end
	end

	assign valid     = out_vld_q;
	assign kind      = kind_q;
	assign resp_func = rfunc_q;
	assign field_a   = fa_q;
	assign field_b   = fb_q;
	assign resp_data = rdata_q;
	assign last      = last_q;

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !out_vld_q)
		else $error("result during clear pass");
	a_s1_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_RDREG || state_q == ST_RDBIT || state_q == ST_DRAIN))
		else $error("read stage valid outside a read");
	a_pend_left: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_kind_q != mse_pkg::PK_NONE) |-> (pend_left_q != '0))
		else $error("pending write with no words left");
	a_wrbit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRBIT) |-> (pend_kind_q == mse_pkg::PK_COILS))
		else $error("coil write pass without pending coil write");

endmodule

FILE: verif/modbus_server_register_coil_engine_checker.sv
// Checker for the Modbus server register/coil engine: tracks the tables, predicts
// every result of each accepted item and compares the result port. Uses mse_pkg.
`timescale 1ns / 1ps

module modbus_server_register_coil_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  func_code,
	input  logic [15:0] start_addr,
	input  logic [15:0] quantity,
	input  logic [15:0] data_word,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        valid,
	input  logic [1:0]  kind,
	input  logic [7:0]  unit_addr,
	input  logic [7:0]  resp_func,
	input  logic [15:0] field_a,
	input  logic [15:0] field_b,
	input  logic [15:0] resp_data,
	input  logic        last,
	output int          fail_count,
	output int          resp_pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  unit;
		logic [7:0]  func;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] data;
		logic        last;
	} resp_t;

	resp_t       resp_q[$];
	logic [7:0]  unit_id;
	logic [15:0] hold_mem[mse_pkg::REG_COUNT];
	logic [15:0] inp_mem[mse_pkg::REG_COUNT];
	logic        coil_mem[mse_pkg::COIL_COUNT];
	logic        disc_mem[mse_pkg::COIL_COUNT];
	logic [1:0]  wr_kind;
	logic [15:0] wr_addr;
	logic [15:0] wr_left;
	logic [15:0] wr_count;

	assign resp_pending = resp_q.size();

	function automatic void push_resp(logic [1:0] k, logic [7:0] f, logic [15:0] a,
			logic [15:0] b, logic [15:0] d, logic l);
		resp_t r;
		r = '{k, unit_id, f, a, b, d, l};
		resp_q.push_back(r);
	endfunction

	function automatic void push_exc(logic [7:0] f, logic [15:0] code);
		push_resp(mse_pkg::KIND_EXC, f | mse_pkg::EXC_FLAG, code, 16'd0, 16'd0, 1'b1);
	endfunction

	function automatic void predict_bit_read(logic [7:0] f, int s, int q);
		int words;
		logic [15:0] v;
		words = (q + 15) / 16;
		if (q < 1 || q > mse_pkg::MAX_BIT_READ) begin
			push_exc(f, mse_pkg::EXC_VALUE);
			return;
		end
		if (s + q - 1 > mse_pkg::COIL_COUNT - 1) begin
			push_exc(f, mse_pkg::EXC_ADDR);
			return;
		end
		push_resp(mse_pkg::KIND_RDHDR, f, 16'((q + 7) / 8), 16'(q), 16'd0, 1'b0);
		for (int w = 0; w < words; w++) begin
			v = '0;
			for (int i = 0; i < 16; i++)
				if (w * 16 + i < q)
					v[i] = (f == mse_pkg::FC_RD_COILS) ? coil_mem[s + w * 16 + i]
						: disc_mem[s + w * 16 + i];
			push_resp(mse_pkg::KIND_DATA, f, 16'd0, 16'd0, v, w + 1 == words);
		end
	endfunction

	function automatic void predict_reg_read(logic [7:0] f, int s, int q);
		if (q < 1 || q > mse_pkg::MAX_REG_READ) begin
			push_exc(f, mse_pkg::EXC_VALUE);
			return;
		end
		if (s + q - 1 > mse_pkg::REG_COUNT - 1) begin
			push_exc(f, mse_pkg::EXC_ADDR);
			return;
		end
		push_resp(mse_pkg::KIND_RDHDR, f, 16'(q * 2), 16'(q), 16'd0, 1'b0);
		for (int w = 0; w < q; w++)
			push_resp(mse_pkg::KIND_DATA, f, 16'd0, 16'd0,
				(f == mse_pkg::FC_RD_HOLD) ? hold_mem[s + w] : inp_mem[s + w],
				w + 1 == q);
	endfunction

	function automatic void predict_header(logic [7:0] f, int s, int q);
		wr_kind = mse_pkg::PK_NONE;
		case (f)
			mse_pkg::FC_RD_COILS, mse_pkg::FC_RD_DISC: predict_bit_read(f, s, q);
			mse_pkg::FC_RD_HOLD, mse_pkg::FC_RD_INP: predict_reg_read(f, s, q);
			mse_pkg::FC_WR_COIL: begin
				if (s > mse_pkg::COIL_COUNT - 1) push_exc(f, mse_pkg::EXC_ADDR);
				else begin
					if (q == mse_pkg::COIL_ON) coil_mem[s] = 1'b1;
					else if (q == mse_pkg::COIL_OFF) coil_mem[s] = 1'b0;
					push_resp(mse_pkg::KIND_ECHO, f, 16'(s), 16'(q), 16'd0, 1'b1);
				end
			end
			mse_pkg::FC_WR_REG: begin
				if (s > mse_pkg::REG_COUNT - 1) push_exc(f, mse_pkg::EXC_ADDR);
				else begin
					hold_mem[s] = 16'(q);
					push_resp(mse_pkg::KIND_ECHO, f, 16'(s), 16'(q), 16'd0, 1'b1);
				end
			end
			mse_pkg::FC_WR_COILS, mse_pkg::FC_WR_REGS: begin
				if (q < 1 || q > ((f == mse_pkg::FC_WR_COILS) ? mse_pkg::MAX_COIL_WRITE
						: mse_pkg::MAX_REG_WRITE))
					push_exc(f, mse_pkg::EXC_VALUE);
				else if (s + q - 1 > ((f == mse_pkg::FC_WR_COILS) ? mse_pkg::COIL_COUNT
						: mse_pkg::REG_COUNT) - 1)
					push_exc(f, mse_pkg::EXC_ADDR);
				else begin
					wr_kind = (f == mse_pkg::FC_WR_COILS) ? mse_pkg::PK_COILS
						: mse_pkg::PK_REGS;
					wr_addr = 16'(s);
					wr_count = 16'(q);
					wr_left = (f == mse_pkg::FC_WR_COILS) ? 16'((q + 15) / 16) : 16'(q);
				end
			end
			default: push_exc(f, mse_pkg::EXC_FUNC);
		endcase
	endfunction

	function automatic void predict_payload(logic [15:0] word);
		int base;
		int idx;
		if (wr_kind == mse_pkg::PK_NONE) return;
		if (wr_kind == mse_pkg::PK_COILS) begin
			base = ((wr_count + 15) / 16 - wr_left) * 16;
			for (int i = 0; i < 16; i++)
				if (base + i < wr_count && wr_addr + base + i < mse_pkg::COIL_COUNT)
					coil_mem[wr_addr + base + i] = word[i];
		end else begin
			idx = wr_addr + (wr_count - wr_left);
			if (idx < mse_pkg::REG_COUNT) hold_mem[idx] = word;
		end
		if (wr_left > 0) wr_left--;
		if (wr_left == 0) begin
			push_resp(mse_pkg::KIND_ECHO,
				(wr_kind == mse_pkg::PK_COILS) ? mse_pkg::FC_WR_COILS : mse_pkg::FC_WR_REGS,
				wr_addr, wr_count, 16'd0, 1'b1);
			wr_kind = mse_pkg::PK_NONE;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		resp_t got, want;
		if (!arst_n) begin
			unit_id = 8'd1;
			for (int i = 0; i < mse_pkg::REG_COUNT; i++) begin
				hold_mem[i] = '0;
				inp_mem[i] = '0;
			end
			for (int i = 0; i < mse_pkg::COIL_COUNT; i++) begin
				coil_mem[i] = 1'b0;
				disc_mem[i] = 1'b0;
			end
			wr_kind = mse_pkg::PK_NONE;
			wr_addr = '0;
			wr_left = '0;
			wr_count = '0;
			resp_q.delete();
			fail_count = 0;
		end else begin
			// compare first: a result never belongs to the item accepted at this edge
			if (valid) begin
				got = '{kind, unit_addr, resp_func, field_a, field_b, resp_data, last};
				if (resp_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected result: expected none actual %h",
							$realtime, got);
				end else begin
					want = resp_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t mismatch: expected %h actual %h",
								$realtime, want, got);
					end
				end
			end
			if (cfg_we) unit_id = cfg_wdata;
			if (start && !busy) begin
				case (op)
					mse_pkg::OP_HDR: predict_header(func_code, start_addr, quantity);
					mse_pkg::OP_PAYLOAD: predict_payload(data_word);
					mse_pkg::OP_LOAD_IR:
						if (start_addr < mse_pkg::REG_COUNT) inp_mem[start_addr] = data_word;
					default:
						if (start_addr < mse_pkg::COIL_COUNT)
							disc_mem[start_addr] = data_word[0];
				endcase
			end
		end
	end

endmodule

FILE: verif/tb_modbus_server_register_coil_engine_top.sv
// Testbench top for the Modbus server register/coil engine: directed and random
// requests, unit id changes between phases. Uses mse_pkg and the checker module.
`timescale 1ns / 1ps

module tb_modbus_server_register_coil_engine_top;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [7:0]  func_code;
	logic [15:0] start_addr;
	logic [15:0] quantity;
	logic [15:0] data_word;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        valid;
	logic [1:0]  kind;
	logic [7:0]  unit_addr;
	logic [7:0]  resp_func;
	logic [15:0] field_a;
	logic [15:0] field_b;
	logic [15:0] resp_data;
	logic        last;
	int          fail_count;
	int          resp_pending;

	modbus_server_register_coil_engine_top u_top (.*);

	modbus_server_register_coil_engine_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// random gap that is never empty, so start never gets two updates in one time step
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
		repeat (n) @(posedge clk);
	endtask

	// Holds start until the item is taken, then, when gaps is set, drops it at random for an idle gap.
	task automatic send_item(logic [1:0] o, logic [7:0] f, logic [15:0] s,
			logic [15:0] q, logic [15:0] d, bit gaps);
		op <= o;
		func_code <= f;
		start_addr <= s;
		quantity <= q;
		data_word <= d;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gaps && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			idle_gap();
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (resp_pending != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_unit(logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic multi_write(logic [7:0] f, logic [15:0] s, logic [15:0] q);
		int words;
		words = (f == mse_pkg::FC_WR_COILS) ? (q + 15) / 16 : q;
		send_item(mse_pkg::OP_HDR, f, s, q, 16'($urandom), 1'b1);
		for (int i = 0; i < words; i++)
			send_item(mse_pkg::OP_PAYLOAD, 8'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 1'b1);
	endtask

	task automatic random_item();
		logic [7:0] f;
		int sel;
		sel = $urandom_range(0, 99);
		f = 8'($urandom_range(1, 8));
		if (f == 7) f = mse_pkg::FC_WR_COILS;
		if (f == 8) f = mse_pkg::FC_WR_REGS;
		if (sel < 8) begin
			send_item(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 1'b1);
		end else if (sel < 20) begin
			send_item(mse_pkg::OP_LOAD_IR, 8'($urandom), 16'($urandom_range(0, 33)),
				16'($urandom), 16'($urandom), 1'b1);
		end else if (sel < 30) begin
			send_item(mse_pkg::OP_LOAD_DI, 8'($urandom), 16'($urandom_range(0, 260)),
				16'($urandom), 16'($urandom), 1'b1);
		end else if (sel < 38) begin
			// abandoned multi-write: header plus a partial payload
			send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_REGS, 16'($urandom_range(0, 20)),
				16'd10, 16'd0, 1'b1);
			repeat ($urandom_range(0, 3))
				send_item(mse_pkg::OP_PAYLOAD, 8'd0, 16'd0, 16'd0, 16'($urandom), 1'b1);
		end else if (sel < 50 && (f == mse_pkg::FC_WR_COILS || f == mse_pkg::FC_WR_REGS)) begin
			if (f == mse_pkg::FC_WR_COILS)
				multi_write(f, 16'($urandom_range(0, 200)), 16'($urandom_range(1, 56)));
			else
				multi_write(f, 16'($urandom_range(0, 28)), 16'($urandom_range(1, 4)));
		end else begin
			case (f)
				mse_pkg::FC_RD_COILS, mse_pkg::FC_RD_DISC:
					send_item(mse_pkg::OP_HDR, f, 16'($urandom_range(0, 255)),
						16'($urandom_range(0, 40)), 16'd0, 1'b1);
				mse_pkg::FC_RD_HOLD, mse_pkg::FC_RD_INP:
					send_item(mse_pkg::OP_HDR, f, 16'($urandom_range(0, 31)),
						16'($urandom_range(0, 8)), 16'd0, 1'b1);
				mse_pkg::FC_WR_COIL:
					send_item(mse_pkg::OP_HDR, f, 16'($urandom_range(0, 260)),
						($urandom_range(0, 3) == 0) ? 16'($urandom)
						: ($urandom_range(0, 1) ? mse_pkg::COIL_ON : mse_pkg::COIL_OFF),
						16'd0, 1'b1);
				mse_pkg::FC_WR_REG:
					send_item(mse_pkg::OP_HDR, f, 16'($urandom_range(0, 34)), 16'($urandom),
						16'd0, 1'b1);
				default:
					send_item(mse_pkg::OP_HDR, 8'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 1'b1);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = mse_pkg::OP_HDR;
		func_code = '0;
		start_addr = '0;
		quantity = '0;
		data_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_unit(8'd247);
		// directed
		send_item(mse_pkg::OP_LOAD_IR, 8'd0, 16'd31, 16'd0, 16'hFFFF, 1'b0);
		send_item(mse_pkg::OP_LOAD_IR, 8'd0, 16'hFFFF, 16'd0, 16'h1234, 1'b0);
		send_item(mse_pkg::OP_LOAD_DI, 8'd0, 16'd255, 16'd0, 16'hFFFF, 1'b0);
		send_item(mse_pkg::OP_LOAD_DI, 8'd0, 16'd256, 16'd0, 16'h0001, 1'b0);
		send_item(mse_pkg::OP_PAYLOAD, 8'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_COIL, 16'd255, mse_pkg::COIL_ON,
			16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_COIL, 16'd3, 16'h1234, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_COIL, 16'd256, mse_pkg::COIL_ON,
			16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_REG, 16'd0, 16'hFFFF, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_REG, 16'hFFFF, 16'd1, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_COILS, 16'd240, 16'd16, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_DISC, 16'd0, 16'd256, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_COILS, 16'd0, 16'd0, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_DISC, 16'd0, 16'd2001, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_COILS, 16'hFFFF, 16'd2000, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_HOLD, 16'd0, 16'd32, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_INP, 16'd31, 16'd126, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_RD_INP, 16'd30, 16'd3, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_COILS, 16'd0, 16'd1969, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, mse_pkg::FC_WR_REGS, 16'd31, 16'd2, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
		send_item(mse_pkg::OP_HDR, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		multi_write(mse_pkg::FC_WR_COILS, 16'd0, 16'd256);
		multi_write(mse_pkg::FC_WR_REGS, 16'd0, 16'd32);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_unit((ph == 0) ? 8'd1 : (ph == 3) ? 8'hFF : 8'($urandom_range(2, 246)));
			for (int n = 0; n < 60; n++) random_item();
			drain();
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
